### rtl/huffman_code_bit_packer_core_assert.svh
// Assertion macros for the code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define HCBP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int MAX_CODE_LEN = 16;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int TABLE_DEPTH  = 256;
  localparam int PEND_W       = 7;
  localparam int ACC_W        = CODE_W + PEND_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int FIFO_CW      = 3;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic encode;
    logic flush;
  } stage_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

  function automatic logic [BYTE_BITS-1:0] flip8(input logic [BYTE_BITS-1:0] v);
    logic [BYTE_BITS-1:0] r;
    for (int i = 0; i < BYTE_BITS; i++) begin
      r[BYTE_BITS-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/hcbp_table.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic                       rd_en,
  input  wire logic [hcbp_pkg::SYM_W-1:0] addr,
  input  wire logic [hcbp_pkg::CODE_W-1:0] wr_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0] wr_len,
  output hcbp_pkg::entry_t                rd_entry,
  output logic                            rd_hit
);

  hcbp_pkg::entry_t mem [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::TABLE_DEPTH-1:0] valid;

  logic [hcbp_pkg::LEN_W-1:0]  len_sat;
  logic [hcbp_pkg::CODE_W:0]   mask;
  hcbp_pkg::entry_t            wr_entry;

  always_comb begin
    if (wr_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) begin
      len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
    end else begin
      len_sat = wr_len;
    end
    mask = ((hcbp_pkg::CODE_W+1)'(1) << len_sat) - (hcbp_pkg::CODE_W+1)'(1);
    wr_entry.len  = len_sat;
    wr_entry.code = wr_word & mask[hcbp_pkg::CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hcbp_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_pack (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hcbp_pkg::stage_t stage,
  input  wire logic             hit,
  input  wire hcbp_pkg::entry_t entry,
  output hcbp_pkg::push_t       push
);

  logic [hcbp_pkg::PEND_W-1:0] pend_bits, pend_bits_next;
  logic [2:0]                  pend_count, pend_count_next;

  logic [hcbp_pkg::ACC_W-1:0]  acc;
  logic [hcbp_pkg::LEN_W-1:0]  total;
  logic [hcbp_pkg::LEN_W-1:0]  rem;
  logic [hcbp_pkg::ACC_W-1:0]  sh0, sh1;
  logic [hcbp_pkg::BYTE_BITS-1:0] rem_mask;
  logic [hcbp_pkg::BYTE_BITS-1:0] flush_byte;

  always_comb begin
    acc = (hcbp_pkg::ACC_W'(pend_bits) << entry.len) | hcbp_pkg::ACC_W'(entry.code);
    total = hcbp_pkg::LEN_W'(pend_count) + entry.len;
    sh0 = acc >> (total - hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS));
    sh1 = acc >> (total - hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_BITS));
    flush_byte = hcbp_pkg::BYTE_BITS'({1'b0, pend_bits} <<
                 (4'(hcbp_pkg::BYTE_BITS) - {1'b0, pend_count}));

    push            = '0;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    rem             = total;

    if (stage.encode && hit) begin
      if (total >= hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_BITS)) begin
        push.count        = 2'd2;
        push.first.data   = hcbp_pkg::flip8(sh0[hcbp_pkg::BYTE_BITS-1:0]);
        push.second.data  = hcbp_pkg::flip8(sh1[hcbp_pkg::BYTE_BITS-1:0]);
        push.second.last  = 1'b1;
        rem               = total - hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_BITS);
      end else if (total >= hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS)) begin
        push.count        = 2'd1;
        push.first.data   = hcbp_pkg::flip8(sh0[hcbp_pkg::BYTE_BITS-1:0]);
        push.first.last   = 1'b1;
        rem               = total - hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS);
      end
      rem_mask        = (hcbp_pkg::BYTE_BITS'(1) << rem[2:0]) - hcbp_pkg::BYTE_BITS'(1);
      pend_count_next = rem[2:0];
      pend_bits_next  = acc[hcbp_pkg::PEND_W-1:0] & rem_mask[hcbp_pkg::PEND_W-1:0];
    end else begin
      rem_mask = '0;
      if (stage.flush && pend_count != 3'd0) begin
        push.count      = 2'd1;
        push.first.data = hcbp_pkg::flip8(flush_byte);
        push.first.last = 1'b1;
        pend_bits_next  = '0;
        pend_count_next = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else begin
      pend_bits  <= pend_bits_next;
      pend_count <= pend_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hcbp_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_out_fifo (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hcbp_pkg::push_t                  push,
  input  wire logic                             pop,
  output hcbp_pkg::out_t                        head_entry,
  output logic [hcbp_pkg::FIFO_CW-1:0]          count
);

  hcbp_pkg::out_t mem [hcbp_pkg::FIFO_DEPTH];
  logic [hcbp_pkg::FIFO_AW-1:0] head, tail;
  logic [hcbp_pkg::FIFO_CW-1:0] count_next;
  logic [hcbp_pkg::FIFO_AW-1:0] tail_next;

  assign head_entry = mem[head];
  assign tail_next  = tail + hcbp_pkg::FIFO_AW'(1);

  always_comb begin
    count_next = count + hcbp_pkg::FIFO_CW'(push.count)
                 - hcbp_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[tail_next] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + hcbp_pkg::FIFO_AW'(pop);
      tail  <= tail + hcbp_pkg::FIFO_AW'(push.count);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/huffman_code_bit_packer_core.sv
// Huffman code bit packer.
// Input channel (item_valid / item_ready) carries req_type, symbol, code_word
// and code_length. A load writes one table entry; an encode appends the
// entry's code to the pending bits and emits each complete byte; a flush
// zero-pads and emits the leftover bits. Unknown or unloaded symbols emit
// nothing.
// Output channel (byte_valid / byte_ready) carries out_byte and last; last
// marks the final byte of one input transaction.
// An encode reads the code table at its accept edge, and an encode or flush
// packs in the next cycle and writes its bytes into the output queue, from
// whose head they are offered.
// Throughput: one load or byte-less item per cycle while the queue is empty;
// an encode or flush reserves two queue entries until it has packed, so a new
// item is taken while one packs only if the queue is empty, and the byte-wide
// output bounds the flow of bytes.
// A four-entry output queue decouples the receiver: a stall fills the queue
// and then drops item_ready, holding all state.
// Reset clears the table valid bits, the pending bits and the output queue;
// it needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_core_assert.svh"

module huffman_code_bit_packer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   code_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    code_length,
  output logic                               byte_valid,
  input  wire logic                          byte_ready,
  output logic [hcbp_pkg::BYTE_BITS-1:0]     out_byte,
  output logic                               last
);

  logic                          accept;
  logic                          is_load, is_encode, is_flush;
  hcbp_pkg::stage_t              stage;
  hcbp_pkg::entry_t              rd_entry;
  logic                          rd_hit;
  hcbp_pkg::push_t               push;
  hcbp_pkg::out_t                head_entry;
  logic [hcbp_pkg::FIFO_CW-1:0]  count;
  logic                          pop;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (req_type)
      hcbp_pkg::REQ_LOAD:   is_load   = 1'b1;
      hcbp_pkg::REQ_ENCODE: is_encode = 1'b1;
      hcbp_pkg::REQ_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign item_ready = (count + ((stage.encode || stage.flush) ? hcbp_pkg::FIFO_CW'(2)
                       : hcbp_pkg::FIFO_CW'(0))) <= hcbp_pkg::FIFO_CW'(2);
  assign accept     = item_valid && item_ready;
  assign byte_valid = count != '0;
  assign pop        = byte_valid && byte_ready;
  assign out_byte   = head_entry.data;
  assign last       = head_entry.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage.encode <= accept && is_encode;
      stage.flush  <= accept && is_flush;
    end
  end

  hcbp_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && is_load),
    .rd_en    (accept && is_encode),
    .addr     (symbol),
    .wr_word  (code_word),
    .wr_len   (code_length),
    .rd_entry (rd_entry),
    .rd_hit   (rd_hit)
  );

  hcbp_pack u_pack (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .hit   (rd_hit),
    .entry (rd_entry),
    .push  (push)
  );

  hcbp_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head_entry (head_entry),
    .count      (count)
  );

  `HCBP_ASSERT_ALWAYS(a_fifo_bound, count <= hcbp_pkg::FIFO_CW'(hcbp_pkg::FIFO_DEPTH), "output queue overflow")
  `HCBP_ASSERT_NEXT(a_load_silent, accept && is_load, push.count == 2'd0, "load produced output")
  `HCBP_ASSERT_ALWAYS(a_last_pos, push.count != 2'd2 || (!push.first.last && push.second.last), "last misplaced")
  `HCBP_ASSERT_NEXT(a_pop_empty, !byte_valid, count <= hcbp_pkg::FIFO_CW'(2), "queue grew past two from empty")

endmodule

`default_nettype wire

### sim/tb_huffman_code_bit_packer_core.sv
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_core;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LEN_CAP = (hcbp_pkg::MAX_CODE_LEN > 16) ? 16 : hcbp_pkg::MAX_CODE_LEN;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  req_type = 2'd0;
  logic [7:0]  symbol = 8'd0;
  logic [15:0] code_word = 16'd0;
  logic [4:0]  code_length = 5'd0;
  logic        byte_valid;
  logic        byte_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  // Prediction state
  bit          code_valid [hcbp_pkg::TABLE_DEPTH];
  logic [4:0]  code_len [hcbp_pkg::TABLE_DEPTH];
  logic [15:0] code_bits [hcbp_pkg::TABLE_DEPTH];
  logic [6:0]  pend_bits = 7'd0;
  logic [2:0]  pend_cnt = 3'd0;

  byte_exp_t   expected_bytes [$];
  byte_exp_t   exp_b;
  logic [7:0]  loaded_syms [$];

  int          mismatches = 0;
  int          tx_next_gap = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  int          stall_left = 0;

  huffman_code_bit_packer_core dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .req_type    (req_type),
    .symbol      (symbol),
    .code_word   (code_word),
    .code_length (code_length),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .out_byte    (out_byte),
    .last        (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7 - i] = v[i];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compute the bytes one accepted transaction produces and queue them.
  task automatic pack_item(input logic [1:0] rt, input logic [7:0] sym,
                           input logic [15:0] cw, input logic [4:0] cl);
    int         len;
    int         total;
    int         n;
    logic [31:0] acc;
    byte_exp_t  outs [2];
    len = cl;
    n = 0;
    if (rt == hcbp_pkg::REQ_LOAD) begin
      if (len > LEN_CAP) len = LEN_CAP;
      code_valid[sym] = 1'b1;
      code_len[sym] = len[4:0];
      code_bits[sym] = 16'((32'(cw)) & ((32'd1 << len) - 32'd1));
    end else if (rt == hcbp_pkg::REQ_ENCODE) begin
      if (code_valid[sym]) begin
        len = code_len[sym];
        acc = (32'(pend_bits) << len) | 32'(code_bits[sym]);
        total = int'(pend_cnt) + len;
        while (total >= 8 && n < 2) begin
          outs[n].data = mirror_byte(8'(acc >> (total - 8)));
          outs[n].last = 1'b0;
          n++;
          total -= 8;
        end
        pend_cnt = 3'(total);
        pend_bits = 7'(acc & ((32'd1 << pend_cnt) - 32'd1));
        if (n > 0) outs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_bytes.push_back(outs[i]);
      end
    end else if (rt == hcbp_pkg::REQ_FLUSH) begin
      if (pend_cnt != 0) begin
        outs[0].data = mirror_byte(8'(32'(pend_bits) << (8 - pend_cnt)));
        outs[0].last = 1'b1;
        expected_bytes.push_back(outs[0]);
        pend_bits = 7'd0;
        pend_cnt = 3'd0;
      end
    end
  endtask

  task automatic send_item(input logic [1:0] rt, input logic [7:0] sym,
                           input logic [15:0] cw, input logic [4:0] cl);
    repeat (tx_next_gap) @(posedge clk);
    item_valid  <= 1'b1;
    req_type    <= rt;
    symbol      <= sym;
    code_word   <= cw;
    code_length <= cl;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pack_item(rt, sym, cw, cl);
    tx_next_gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (tx_next_gap != 0) item_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tx_next_gap = 0;
  endtask

  task automatic send_random_item(output bit ignored);
    int          pick;
    logic [1:0]  rt;
    logic [7:0]  sym;
    logic [15:0] cw;
    logic [4:0]  cl;
    pick = $urandom_range(0, 99);
    sym = 8'($urandom_range(0, 255));
    cw = 16'($urandom_range(0, 65535));
    cl = 5'($urandom_range(0, 16));
    if ($urandom_range(0, 9) == 0) cl = 5'($urandom_range(0, 31));
    ignored = 1'b0;
    if (pick < 12 || loaded_syms.size() == 0) begin
      rt = hcbp_pkg::REQ_LOAD;
      loaded_syms.push_back(sym);
    end else if (pick < 80) begin
      rt = hcbp_pkg::REQ_ENCODE;
      sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    end else if (pick < 88) begin
      rt = hcbp_pkg::REQ_ENCODE;
    end else if (pick < 96) begin
      rt = hcbp_pkg::REQ_FLUSH;
    end else begin
      rt = REQ_UNUSED;
      ignored = 1'b1;
    end
    send_item(rt, sym, cw, cl);
  endtask

  task automatic run_stream(input int count);
    int n;
    bit ign;
    n = 0;
    while (n < count) begin
      send_random_item(ign);
      if (!ign) n++;
    end
  endtask

  task automatic test_edge_codes();
    send_item(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h01, 16'hFFFF, 5'd31);
    send_item(REQ_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
    send_item(hcbp_pkg::REQ_LOAD, 8'h00, 16'hFFFF, 5'd16);
    send_item(hcbp_pkg::REQ_LOAD, 8'hFF, 16'h1234, 5'd0);
    send_item(hcbp_pkg::REQ_LOAD, 8'h55, 16'hABCD, 5'd31);
    send_item(hcbp_pkg::REQ_LOAD, 8'hAA, 16'hFFFF, 5'd3);
    send_item(hcbp_pkg::REQ_LOAD, 8'h0F, 16'h0001, 5'd1);
    send_item(hcbp_pkg::REQ_LOAD, 8'hF0, 16'h007F, 5'd7);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h00, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'hFF, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'hAA, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h0F, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'hF0, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h55, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h00, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_LOAD, 8'h0F, 16'h0000, 5'd17);
    send_item(hcbp_pkg::REQ_ENCODE, 8'h0F, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_ENCODE, 8'hAA, 16'h0000, 5'd0);
    send_item(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
    foreach (code_valid[i]) if (code_valid[i]) loaded_syms.push_back(8'(i));
    wait_for_drain();
  endtask

  task automatic test_dense_stream();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    run_stream(100);
  endtask

  task automatic test_idle_stream();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    run_stream(200);
  endtask

  task automatic test_receiver_stall();
    tx_gaps = 1'b0;
    rx_stalls = 1'b1;
    for (int k = 0; k < 5; k++) begin
      run_stream(25);
      wait_for_drain();
    end
  endtask

  // Receiver: random stalls, mostly short
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      byte_ready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      byte_ready <= 1'b0;
    end else begin
      byte_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && byte_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last));
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_byte !== exp_b.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, exp_b.data));
        if (last !== exp_b.last)
          report_mismatch($sformatf("last %0b, want %0b", last, exp_b.last));
      end
    end
  end

  initial begin
    foreach (code_valid[i]) begin
      code_valid[i] = 1'b0;
      code_len[i] = 5'd0;
      code_bits[i] = 16'd0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_edge_codes();
    test_dense_stream();
    test_idle_stream();
    test_receiver_stall();
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) report_mismatch("bytes still expected");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
